FILE: rtl/solve_linear_3x3_core_assert.svh
// assertion macros used by the solver core
`ifndef SOLVE_LINEAR_3X3_CORE_ASSERT_SVH
`define SOLVE_LINEAR_3X3_CORE_ASSERT_SVH

// implication checked outside reset
`define SL3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define SL3_ASSERT_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sl3_pkg.sv
package sl3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

endpackage

FILE: rtl/sl3_if.sv
interface sl3_sys_if #(
  parameter int DW = sl3_pkg::DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [DW-1:0] b0, b1, b2;

  modport source (
    output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2,
    input  ready
  );
  modport sink (
    input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2,
    output ready
  );
endinterface

interface sl3_sol_if #(
  parameter int DW = sl3_pkg::DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [DW-1:0] x0, x1, x2;
  logic singular;

  modport source (output valid, x0, x1, x2, singular, input ready);
  modport sink (input valid, x0, x1, x2, singular, output ready);
endinterface

FILE: rtl/solve_linear_3x3_core.sv
// throughput: one system per cycle unless the result side stalls; the quotient
// takes one bit per stage over DATA_WIDTH stages of the three divider lanes
// a stall on the result side holds the whole pipeline in place
// reset clears the valid bits only; no clearing pass, ready right after reset
`include "solve_linear_3x3_core_assert.svh"

module solve_linear_3x3_core #(
  parameter int DATA_WIDTH = sl3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sl3_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sl3_sys_if.sink   sys,
  sl3_sol_if.source sol
);

  localparam int SW = 3 * DATA_WIDTH + 2;

  logic                         en;
  logic signed [DATA_WIDTH-1:0] a [9];
  logic signed [DATA_WIDTH-1:0] b [3];
  logic                         fv;
  logic signed [SW-1:0]         det;
  logic signed [SW-1:0]         s [3];
  logic                         vo [3];
  logic                         sg [3];
  logic signed [DATA_WIDTH-1:0] xo [3];

  assign en        = !sol.valid || sol.ready;
  assign sys.ready = en;

  assign a[0] = sys.a00;
  assign a[1] = sys.a01;
  assign a[2] = sys.a02;
  assign a[3] = sys.a10;
  assign a[4] = sys.a11;
  assign a[5] = sys.a12;
  assign a[6] = sys.a20;
  assign a[7] = sys.a21;
  assign a[8] = sys.a22;
  assign b[0] = sys.b0;
  assign b[1] = sys.b1;
  assign b[2] = sys.b2;

  sl3_front #(
    .W (DATA_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (sys.valid),
    .a     (a),
    .b     (b),
    .v_out (fv),
    .det   (det),
    .s     (s)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sl3_div #(
      .W (DATA_WIDTH),
      .F (FRAC_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (fv),
      .s        (s[i]),
      .d        (det),
      .v_out    (vo[i]),
      .x        (xo[i]),
      .singular (sg[i])
    );
  end

  assign sol.valid    = vo[0];
  assign sol.x0       = xo[0];
  assign sol.x1       = xo[1];
  assign sol.x2       = xo[2];
  assign sol.singular = sg[0];

  `SL3_ASSERT_IMP(a_singular_zero, clk, rst, sol.valid && sol.singular,
    sol.x0 == '0 && sol.x1 == '0 && sol.x2 == '0, "singular word with nonzero solution")
  `SL3_ASSERT_IMP(a_stall_blocks_input, clk, rst, sol.valid && !sol.ready, !sys.ready,
    "input taken while result word stalled")
  `SL3_ASSERT_IMP(a_lanes_aligned, clk, rst, sol.valid,
    vo[1] && vo[2] && sg[1] == sg[0] && sg[2] == sg[0], "divider lanes out of step")
  `SL3_ASSERT_NXT(a_reset_empty, clk, rst, !sol.valid, "result word valid after reset")

endmodule

FILE: rtl/sl3_front.sv
module sl3_front #(
  parameter int W = sl3_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v_in,
  input  logic signed [W-1:0]   a [9],
  input  logic signed [W-1:0]   b [3],
  output logic                  v_out,
  output logic signed [3*W+1:0] det,
  output logic signed [3*W+1:0] s [3]
);

  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int HW = 2 * W + 1;
  localparam int FW = 3 * W + 1;
  localparam int SW = 3 * W + 2;

  function automatic int oth(input int k, input int n);
    int r;
    if (n == 0) r = (k == 0) ? 1 : 0;
    else r = (k == 2) ? 1 : 2;
    return r;
  endfunction

  logic v1, v2, v3, v4, v5;

  logic signed [PW-1:0] pa [9];
  logic signed [PW-1:0] pb [9];
  logic signed [W-1:0]  a0_1 [3], b_1 [3];
  logic signed [CW-1:0] cof_next [9];
  logic signed [CW-1:0] cof [9];
  logic signed [W-1:0]  a0_2 [3], b_2 [3];
  logic signed [W-1:0]  mx [12];
  logic signed [CW-1:0] mc [12];
  logic signed [HW-1:0] pl [12];
  logic signed [HW-1:0] ph [12];
  logic signed [FW-1:0] pf [12];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= v_in;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // two by two minor products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa[i*3+j] <= a[oth(i, 0)*3+oth(j, 0)] * a[oth(i, 1)*3+oth(j, 1)];
          pb[i*3+j] <= a[oth(i, 0)*3+oth(j, 1)] * a[oth(i, 1)*3+oth(j, 0)];
        end
        a0_1[i] <= a[i];
        b_1[i]  <= b[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (((i + j) & 1) != 0) begin
          cof_next[i*3+j] = CW'(pb[i*3+j]) - CW'(pa[i*3+j]);
        end else begin
          cof_next[i*3+j] = CW'(pa[i*3+j]) - CW'(pb[i*3+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cof  <= cof_next;
      a0_2 <= a0_1;
      b_2  <= b_1;
    end
  end

  // operand routing: determinant terms first, then adjugate times b
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mx[j] = a0_2[j];
      mc[j] = cof[j];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mx[3+i*3+j] = b_2[j];
        mc[3+i*3+j] = cof[j*3+i];
      end
    end
  end

  // split products, low half unsigned, high half signed
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 12; t++) begin
        pl[t] <= mx[t] * $signed({1'b0, mc[t][W-1:0]});
        ph[t] <= mx[t] * $signed(mc[t][CW-1:W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 12; t++) begin
        pf[t] <= $signed({ph[t], {W{1'b0}}}) + $signed({{W{pl[t][HW-1]}}, pl[t]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= SW'(pf[0]) + SW'(pf[1]) + SW'(pf[2]);
      for (int i = 0; i < 3; i++) begin
        s[i] <= SW'(pf[3+i*3]) + SW'(pf[3+i*3+1]) + SW'(pf[3+i*3+2]);
      end
    end
  end

  assign v_out = v5;

endmodule

FILE: rtl/sl3_div.sv
module sl3_div #(
  parameter int W = sl3_pkg::DATA_WIDTH_DEF,
  parameter int F = sl3_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v_in,
  input  logic signed [3*W+1:0] s,
  input  logic signed [3*W+1:0] d,
  output logic                  v_out,
  output logic signed [W-1:0]   x,
  output logic                  singular
);

  localparam int SW = 3 * W + 2;
  localparam int XW = SW + W + F + 1;

  logic [SW-1:0] smag, dmag;
  logic          pv, pneg, pzero;
  logic [XW-1:0] pn, pd;

  logic          vv [W+1];
  logic          ng [W+1];
  logic          zr [W+1];
  logic          sa [W+1];
  logic [XW-1:0] rr [W+1];
  logic [XW-1:0] dd [W+1];
  logic [W-1:0]  qq [W+1];

  logic [XW-1:0] dsh [W];
  logic          ge [W];
  logic [XW-1:0] r_next [W];

  logic [W:0]    qf, lim, mag;
  logic [W-1:0]  res;

  assign smag = s[SW-1] ? SW'(~s + 1'b1) : SW'(s);
  assign dmag = d[SW-1] ? SW'(~d + 1'b1) : SW'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      for (int n = 0; n <= W; n++) vv[n] <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      pv    <= v_in;
      vv[0] <= pv;
      for (int n = 1; n <= W; n++) vv[n] <= vv[n-1];
      v_out <= vv[W];
    end
  end

  // magnitudes, sign and zero-divisor flag
  always_ff @(posedge clk) begin
    if (en) begin
      pn    <= XW'(smag) << F;
      pd    <= XW'(dmag);
      pneg  <= s[SW-1] ^ d[SW-1];
      pzero <= (d == '0);
    end
  end

  // overflow check, then one quotient bit per stage
  always_comb begin
    for (int n = 1; n <= W; n++) begin
      dsh[n-1]    = dd[n-1] << (W - n);
      ge[n-1]     = (rr[n-1] >= dsh[n-1]);
      r_next[n-1] = ge[n-1] ? (rr[n-1] - dsh[n-1]) : rr[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= (pn >= (pd << W));
      rr[0] <= pn;
      dd[0] <= pd;
      qq[0] <= '0;
      ng[0] <= pneg;
      zr[0] <= pzero;
      for (int n = 1; n <= W; n++) begin
        sa[n] <= sa[n-1];
        rr[n] <= r_next[n-1];
        dd[n] <= dd[n-1];
        qq[n] <= {qq[n-1][W-2:0], ge[n-1]};
        ng[n] <= ng[n-1];
        zr[n] <= zr[n-1];
      end
    end
  end

  // round half away from zero, saturate, apply sign
  always_comb begin
    qf  = {1'b0, qq[W]} + (W+1)'((rr[W] << 1) >= dd[W]);
    lim = ng[W] ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    mag = (sa[W] || (qf > lim)) ? lim : qf;
    res = ng[W] ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x        <= zr[W] ? '0 : $signed(res);
      singular <= zr[W];
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

typedef logic signed [31:0] q16_t;
typedef logic signed [191:0] exact_t;

typedef struct {
  q16_t m[9];
  q16_t v[3];
} system_t;

typedef struct {
  q16_t x[3];
  logic singular;
} solution_t;

class solution_board;
  solution_t pending[$];
  int errors = 0;

  function automatic q16_t round_quotient(exact_t n, exact_t d);
    logic neg;
    exact_t num, den, q, r;
    neg = (n < 0) != (d < 0);
    num = (n < 0) ? -n : n;
    den = (d < 0) ? -d : d;
    num = num <<< 16;
    q = num / den;
    r = num % den;
    if (2 * r >= den) q = q + 1;
    if (neg && q > 192'sd2147483648) q = 192'sd2147483648;
    if (!neg && q > 192'sd2147483647) q = 192'sd2147483647;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic solution_t predict(system_t s);
    exact_t e[3][3], c[3][3], bv[3], det, acc;
    int r0, r1, c0, c1;
    solution_t res;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) e[i][j] = exact_t'(s.m[i*3+j]);
      bv[i] = exact_t'(s.v[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        c[i][j] = e[r0][c0] * e[r1][c1] - e[r0][c1] * e[r1][c0];
        if ((i + j) % 2 == 1) c[i][j] = -c[i][j];
      end
    end
    det = 0;
    for (int j = 0; j < 3; j++) det = det + e[0][j] * c[0][j];
    res.singular = (det == 0);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc = acc + c[j][i] * bv[j];
      res.x[i] = res.singular ? '0 : round_quotient(acc, det);
    end
    return res;
  endfunction

  function void note(system_t s);
    pending.push_back(predict(s));
  endfunction

  function void check(solution_t got);
    solution_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected solution word x=%h %h %h singular=%b", $time,
               got.x[0], got.x[1], got.x[2], got.singular);
      errors++;
      return;
    end
    want = pending.pop_front();
    for (int i = 0; i < 3; i++)
      if (got.x[i] !== want.x[i]) begin
        $display("%0t: x%0d expected %h actual %h", $time, i, want.x[i], got.x[i]);
        errors++;
      end
    if (got.singular !== want.singular) begin
      $display("%0t: singular expected %b actual %b", $time, want.singular,
               got.singular);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst;
  solution_board board = new();
  int sent = 0;
  int taken = 0;
  bit sending_done = 0;

  sl3_sys_if sys_ch();
  sl3_sol_if sol_ch();

  solve_linear_3x3_core DUT (.clk(clk), .rst(rst), .sys(sys_ch), .sol(sol_ch));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic q16_t pick_value(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return 32'sh00010000;
          4: return $signed($urandom_range(0, 15)) - 8;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic system_t random_system();
    system_t s;
    int mode, p;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < 9; i++) s.m[i] = pick_value(mode);
    for (int i = 0; i < 3; i++) s.v[i] = pick_value(mode);
    p = $urandom_range(0, 9);
    if (p == 0) for (int j = 0; j < 3; j++) s.m[6+j] = s.m[j];
    if (p == 1) for (int i = 0; i < 3; i++) s.m[i*3+1] = 0;
    if (p == 2) for (int j = 0; j < 3; j++) s.m[3+j] = -s.m[j];
    return s;
  endfunction

  function automatic system_t diag_system(q16_t d0, q16_t d1, q16_t d2,
                                          q16_t v0, q16_t v1, q16_t v2);
    system_t s;
    for (int i = 0; i < 9; i++) s.m[i] = 0;
    s.m[0] = d0;
    s.m[4] = d1;
    s.m[8] = d2;
    s.v[0] = v0;
    s.v[1] = v1;
    s.v[2] = v2;
    return s;
  endfunction

  task automatic send_word(system_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sys_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    sys_ch.valid <= 1;
    {sys_ch.a00, sys_ch.a01, sys_ch.a02} <= {s.m[0], s.m[1], s.m[2]};
    {sys_ch.a10, sys_ch.a11, sys_ch.a12} <= {s.m[3], s.m[4], s.m[5]};
    {sys_ch.a20, sys_ch.a21, sys_ch.a22} <= {s.m[6], s.m[7], s.m[8]};
    {sys_ch.b0, sys_ch.b1, sys_ch.b2} <= {s.v[0], s.v[1], s.v[2]};
    do @(posedge clk); while (!sys_ch.ready);
    board.note(s);
    sent++;
  endtask

  task automatic send_directed();
    system_t s;
    localparam q16_t ONE = 32'sh00010000;
    localparam q16_t MAXV = 32'sh7fffffff;
    localparam q16_t MINV = 32'sh80000000;
    send_word(diag_system(ONE, ONE, ONE, ONE, -ONE, MAXV));
    send_word(diag_system(0, 0, 0, 5, 6, 7));
    send_word(diag_system(MAXV, MAXV, MAXV, MAXV, MINV, 1));
    send_word(diag_system(MINV, MINV, MINV, MINV, MAXV, -1));
    send_word(diag_system(1, 1, 1, MAXV, MINV, 3));
    send_word(diag_system(-1, 1, -1, MINV, MINV, MAXV));
    // half-way ties round away from zero
    send_word(diag_system(32'sh00020000, 1, 1, 1, 0, 0));
    send_word(diag_system(32'sh00020000, 1, 1, -1, 0, 0));
    send_word(diag_system(3, 32'sh00030000, 7, 1, 2, -5));
    send_word(diag_system(ONE, MAXV, MINV, 0, 0, 0));
    for (int i = 0; i < 9; i++) s.m[i] = MAXV;
    s.v = '{MAXV, MINV, 0};
    send_word(s);
    for (int i = 0; i < 9; i++) s.m[i] = MINV;
    s.v = '{MINV, MINV, MINV};
    send_word(s);
    s.m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE};
    s.v = '{ONE, ONE, ONE};
    send_word(s);
    s.m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE};
    send_word(s);
    s.m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
    s.v = '{MAXV, MINV, 32'sh12345678};
    send_word(s);
    s.m = '{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, 1};
    s.v = '{1, -1, MAXV};
    send_word(s);
  endtask

  initial begin
    rst <= 1;
    sys_ch.valid <= 0;
    {sys_ch.a00, sys_ch.a01, sys_ch.a02} <= '0;
    {sys_ch.a10, sys_ch.a11, sys_ch.a12} <= '0;
    {sys_ch.a20, sys_ch.a21, sys_ch.a22} <= '0;
    {sys_ch.b0, sys_ch.b1, sys_ch.b2} <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_directed();
    for (int n = 0; n < 1830; n++) begin
      if (n == 900) begin
        sys_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      send_word(random_system());
    end
    sys_ch.valid <= 0;
    sending_done = 1;
  end

  // result side with random ready and one long hold-off
  initial begin
    solution_t got;
    bit held = 0;
    sol_ch.ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sol_ch.valid && sol_ch.ready) begin
        for (int i = 0; i < 3; i++) got.x[i] = (i == 0) ? sol_ch.x0 :
                                              (i == 1) ? sol_ch.x1 : sol_ch.x2;
        got.singular = sol_ch.singular;
        board.check(got);
        taken++;
      end
      if (!held && taken >= 300) begin
        held = 1;
        sol_ch.ready <= 0;
        repeat (400) @(posedge clk);
        sol_ch.ready <= 1;
      end else if ($urandom_range(0, 99) < 8) begin
        sol_ch.ready <= 0;
        repeat ($urandom_range(0, 99) < 85 ? $urandom_range(1, 3)
                                           : $urandom_range(10, 40)) @(posedge clk);
        sol_ch.ready <= 1;
      end else begin
        sol_ch.ready <= ($urandom_range(0, 3) != 0) || (taken % 200 < 40);
      end
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
